FILE: rtl/core/hmt_pkg.sv
`default_nettype none
package hmt_pkg;

    localparam int MAX_DELTA_BYTES = 4;
    localparam int COUNT_BITS_DEF = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int BW_BITS = 16;

    localparam int DC_W = $clog2(MAX_DELTA_BYTES);
    localparam int NB_W = $clog2(MAX_DELTA_BYTES + 1);

    localparam logic [1:0] ST_BYTE = 2'd0;
    localparam logic [1:0] ST_END = 2'd1;
    localparam logic [1:0] ST_LEN = 2'd2;
    localparam logic [1:0] ST_ERR = 2'd3;

    localparam logic [7:0] BYTE_TOP = 8'h80;
    localparam logic [7:0] BYTE_META = 8'hFF;
    localparam logic [7:0] META_EOT = 8'h2F;
    localparam logic [3:0] NIB_SYS = 4'hF;
    localparam logic [3:0] NIB_PROG = 4'hC;
    localparam logic [3:0] NIB_PRESS = 4'hD;

    typedef struct packed {
        logic [MAX_DELTA_BYTES-1:0][7:0] bytes;
        logic [NB_W-1:0]                 nb;
        logic                            end_trk;
        logic                            len_end;
        logic                            err;
        logic                            start;
    } t_job;

endpackage
`default_nettype wire

FILE: rtl/core/hmt_in_if.sv
`default_nettype none
interface hmt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       track_start;
    logic       track_last;

    modport source (output valid, output in_byte, output track_start, output track_last,
                    input ready);
    modport sink (input valid, input in_byte, input track_start, input track_last,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/core/hmt_out_if.sv
`default_nettype none
interface hmt_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [1:0]  status;
    logic        run_last;
    logic [15:0] bytes_written;

    modport source (output valid, output out_byte, output status, output run_last,
                    output bytes_written, input ready);
    modport sink (input valid, input out_byte, input status, input run_last,
                  input bytes_written, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/hmt_front.sv
`default_nettype none
module hmt_front (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    hmt_in_if.sink       i_in,
    input  wire logic    i_q_ready,
    output logic         o_push,
    output hmt_pkg::t_job o_job
);
    import hmt_pkg::*;

    localparam logic [2:0] PH_DELTA = 3'd0;
    localparam logic [2:0] PH_STATUS = 3'd1;
    localparam logic [2:0] PH_CHDATA = 3'd2;
    localparam logic [2:0] PH_MTYPE = 3'd3;
    localparam logic [2:0] PH_MLEN = 3'd4;
    localparam logic [2:0] PH_MDATA = 3'd5;
    localparam logic [2:0] PH_DONE = 3'd6;
    localparam logic [2:0] PH_ERROR = 3'd7;

    logic [2:0]      r_phase, n_phase;
    logic [6:0]      r_store [MAX_DELTA_BYTES-1];
    logic [6:0]      n_store [MAX_DELTA_BYTES-1];
    logic [DC_W-1:0] r_dc, n_dc;
    logic [7:0]      r_rs, n_rs;
    logic [1:0]      r_dr, n_dr;
    logic [7:0]      r_mr, n_mr;
    logic            r_me, n_me;
    logic            accept;
    t_job            job;

    assign i_in.ready = i_q_ready;
    assign accept = i_in.valid && i_q_ready;

    always_comb begin
        logic [2:0]      e_phase;
        logic [DC_W-1:0] e_dc;
        logic [7:0]      e_rs;
        logic [1:0]      e_dr;
        logic [7:0]      e_mr;
        logic            e_me;
        logic            was_idle;
        logic [7:0]      b;

        b = i_in.in_byte;
        e_phase = i_in.track_start ? PH_DELTA : r_phase;
        e_dc = i_in.track_start ? '0 : r_dc;
        e_rs = i_in.track_start ? 8'h00 : r_rs;
        e_dr = i_in.track_start ? 2'd0 : r_dr;
        e_mr = i_in.track_start ? 8'h00 : r_mr;
        e_me = i_in.track_start ? 1'b0 : r_me;
        was_idle = (e_phase == PH_DONE) || (e_phase == PH_ERROR);

        n_phase = e_phase;
        n_dc = e_dc;
        n_rs = e_rs;
        n_dr = e_dr;
        n_mr = e_mr;
        n_me = e_me;
        n_store = r_store;
        job = '0;
        job.start = i_in.track_start;

        case (e_phase)
            PH_DELTA: begin
                if (b[7]) begin
                    job.nb = NB_W'(e_dc) + NB_W'(1);
                    job.bytes[0] = {(e_dc != '0), b[6:0]};
                    for (int j = 1; j < MAX_DELTA_BYTES; j++) begin
                        job.bytes[j] = {(j < int'(e_dc)), r_store[j-1]};
                    end
                    n_dc = '0;
                    n_phase = PH_STATUS;
                end else if (e_dc == DC_W'(MAX_DELTA_BYTES - 1)) begin
                    job.err = 1'b1;
                    n_phase = PH_ERROR;
                end else begin
                    n_store[0] = b[6:0];
                    for (int i = 1; i < MAX_DELTA_BYTES - 1; i++) begin
                        n_store[i] = r_store[i-1];
                    end
                    n_dc = e_dc + DC_W'(1);
                end
            end
            PH_STATUS: begin
                if (b == BYTE_META) begin
                    job.nb = NB_W'(1);
                    job.bytes[0] = b;
                    n_phase = PH_MTYPE;
                end else if (!b[7] || (b[7:4] == NIB_SYS)) begin
                    job.err = 1'b1;
                    n_phase = PH_ERROR;
                end else begin
                    n_dr = ((b[7:4] == NIB_PROG) || (b[7:4] == NIB_PRESS)) ? 2'd1 : 2'd2;
                    if (b != e_rs) begin
                        job.nb = NB_W'(1);
                        job.bytes[0] = b;
                    end
                    n_rs = b;
                    n_phase = PH_CHDATA;
                end
            end
            PH_CHDATA: begin
                job.nb = NB_W'(1);
                job.bytes[0] = b;
                n_dr = (e_dr != 2'd0) ? e_dr - 2'd1 : 2'd0;
                if (n_dr == 2'd0) begin
                    n_phase = PH_DELTA;
                end
            end
            PH_MTYPE: begin
                job.nb = NB_W'(1);
                job.bytes[0] = b;
                n_me = (b == META_EOT);
                n_phase = PH_MLEN;
            end
            PH_MLEN: begin
                job.nb = NB_W'(1);
                job.bytes[0] = b;
                n_mr = b;
                if (b == 8'h00) begin
                    job.end_trk = e_me;
                    n_phase = e_me ? PH_DONE : PH_DELTA;
                end else begin
                    n_phase = PH_MDATA;
                end
            end
            PH_MDATA: begin
                job.nb = NB_W'(1);
                job.bytes[0] = b;
                n_mr = (e_mr != 8'h00) ? e_mr - 8'h01 : 8'h00;
                if (n_mr == 8'h00) begin
                    job.end_trk = e_me;
                    n_phase = e_me ? PH_DONE : PH_DELTA;
                end
            end
            default: begin
            end
        endcase

        if (i_in.track_last && !was_idle && (n_phase != PH_DONE) && (n_phase != PH_ERROR)) begin
            if ((n_phase == PH_DELTA) && (n_dc == '0)) begin
                job.len_end = 1'b1;
                n_phase = PH_DONE;
            end else begin
                job.err = 1'b1;
                n_phase = PH_ERROR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DELTA;
            r_dc <= '0;
            r_rs <= 8'h00;
            r_dr <= 2'd0;
            r_mr <= 8'h00;
            r_me <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_dc <= n_dc;
            r_rs <= n_rs;
            r_dr <= n_dr;
            r_mr <= n_mr;
            r_me <= n_me;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_store <= n_store;
        end
    end

    assign o_push = accept && ((job.nb != '0) || job.len_end || job.err || job.start);
    assign o_job = job;

endmodule
`default_nettype wire

FILE: rtl/core/hmt_queue.sv
`default_nettype none
module hmt_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire hmt_pkg::t_job i_job,
    output logic               o_ready,
    output logic               o_valid,
    output hmt_pkg::t_job      o_job,
    input  wire logic          i_pop
);
    import hmt_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job           r_mem [QUEUE_DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;
    logic           do_push, do_pop;

    assign o_ready = (r_cnt != CW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/hmt_back.sv
`default_nettype none
module hmt_back #(
    parameter int COUNT_BITS = hmt_pkg::COUNT_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire hmt_pkg::t_job i_job,
    output logic               o_pop,
    hmt_out_if.source          o_out
);
    import hmt_pkg::*;

    logic [NB_W-1:0]       r_k, n_k;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_ov, n_ov;
    logic [7:0]            r_byte, n_byte;
    logic [1:0]            r_stat, n_stat;
    logic                  r_last, n_last;
    logic [BW_BITS-1:0]    r_bw, n_bw;
    logic                  can_emit;

    assign can_emit = !r_ov || o_out.ready;

    always_comb begin
        logic [COUNT_BITS-1:0] base;
        logic [COUNT_BITS:0]   sum;
        logic [COUNT_BITS-1:0] cnt;
        logic [NB_W:0]         total;

        base = (i_job.start && (r_k == '0)) ? '0 : r_count;
        total = i_job.err ? (NB_W+1)'(1)
                          : {1'b0, i_job.nb} + (NB_W+1)'(i_job.len_end);
        sum = {1'b0, base} + (COUNT_BITS+1)'(i_job.err ? i_job.nb : NB_W'(1));
        cnt = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];

        n_k = r_k;
        n_count = r_count;
        n_ov = r_ov;
        n_byte = r_byte;
        n_stat = r_stat;
        n_last = r_last;
        n_bw = r_bw;
        o_pop = 1'b0;

        if (can_emit) begin
            n_ov = 1'b0;
            if (i_valid) begin
                if (total == '0) begin
                    n_count = base;
                    o_pop = 1'b1;
                end else begin
                    n_ov = 1'b1;
                    n_last = ({1'b0, r_k} == total - (NB_W+1)'(1));
                    if (i_job.err) begin
                        n_byte = 8'h00;
                        n_stat = ST_ERR;
                        n_count = cnt;
                    end else if (r_k < i_job.nb) begin
                        n_byte = i_job.bytes[r_k[DC_W-1:0]];
                        n_stat = (i_job.end_trk && (r_k == i_job.nb - NB_W'(1)))
                                 ? ST_END : ST_BYTE;
                        n_count = cnt;
                    end else begin
                        n_byte = 8'h00;
                        n_stat = ST_LEN;
                        n_count = base;
                    end
                    n_bw = BW_BITS'(n_count);
                    if (n_last) begin
                        o_pop = 1'b1;
                        n_k = '0;
                    end else begin
                        n_k = r_k + NB_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
            r_count <= '0;
            r_ov <= 1'b0;
        end else begin
            r_k <= n_k;
            r_count <= n_count;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_stat <= n_stat;
        r_last <= n_last;
        r_bw <= n_bw;
    end

    assign o_out.valid = r_ov;
    assign o_out.out_byte = r_byte;
    assign o_out.status = r_stat;
    assign o_out.run_last = r_last;
    assign o_out.bytes_written = r_bw;

endmodule
`default_nettype wire

FILE: rtl/core/hmi_to_midi_track_transcoder_core.sv
// Channel   Dir  Payload                                                 Handshake
// i_in      in   in_byte[8], track_start, track_last                     valid/ready
// o_out     out  out_byte[8], status[2], run_last, bytes_written[16]     valid/ready
//
// The front parser takes one beat per cycle while the job queue has room.
// A beat that yields results or starts a track becomes one job; the back end emits
// its results one at a time and pops a job without results silently, so a beat yields up to four results.
// Each job passes through the job queue and then the registered output stage.
// Reset is synchronous and clears the parser, the queue and the output stage.
// A stalled output holds its beat while the front keeps filling the queue.
`default_nettype none
module hmi_to_midi_track_transcoder_core #(
    parameter int COUNT_BITS = hmt_pkg::COUNT_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hmt_in_if.sink    i_in,
    hmt_out_if.source o_out
);
    import hmt_pkg::*;

    logic push, q_ready, q_valid, pop;
    t_job push_job, head_job;

    hmt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_job     (push_job)
    );

    hmt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_job   (head_job),
        .i_pop   (pop)
    );

    hmt_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

FILE: rtl/core/hmt_checker.sv
`default_nettype none
module hmt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [7:0]  i_out_byte,
    input wire logic [1:0]  i_status,
    input wire logic        i_run_last,
    input wire logic [15:0] i_bytes_written
);
    import hmt_pkg::*;

    a_len_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == ST_LEN)) |-> (i_run_last && (i_out_byte == 8'h00)))
        else $error("length-end beat is not the final zero beat of its input");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == ST_ERR)) |-> (i_run_last && (i_out_byte == 8'h00)))
        else $error("error beat is not the single zero beat of its input");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_byte) && $stable(i_status)
             && $stable(i_run_last) && $stable(i_bytes_written)))
        else $error("stalled output beat changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind hmi_to_midi_track_transcoder_core hmt_checker u_hmt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_byte      (o_out.out_byte),
    .i_status        (o_out.status),
    .i_run_last      (o_out.run_last),
    .i_bytes_written (o_out.bytes_written)
);
`default_nettype wire

FILE: tb/hmi_to_midi_track_transcoder_core_tb.sv
module hmi_to_midi_track_transcoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hmt_pkg::*;

    localparam int unsigned RANDOM_BEATS = 232;
    localparam int unsigned RESULT_ROOM = 5;
    localparam int unsigned MAX_HELD = MAX_DELTA_BYTES - 1;
    localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS_DEF) - 1;

    typedef enum logic [2:0] {
        AWAIT_DELTA,
        AWAIT_STATUS,
        CHAN_DATA,
        META_TYPE,
        META_LEN,
        META_DATA,
        TRACK_DONE,
        TRACK_ERROR
    } t_parse_phase;

    typedef struct {
        logic [7:0]  in_byte;
        logic        track_start;
        logic        track_last;
        int unsigned pace;
    } t_track_beat;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [1:0]  status;
        logic        run_last;
        logic [15:0] bytes_written;
    } t_midi_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    hmt_in_if  in_ch ();
    hmt_out_if out_ch ();

    hmi_to_midi_track_transcoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #1 i_clk = ~i_clk;

    int unsigned sender_idle_pct [3] = '{37, 75, 0};
    int unsigned receiver_idle_pct [3] = '{75, 37, 0};

    t_track_beat  track_beats [$];
    logic [7:0]   trk [$];
    t_midi_beat   midi_expected [$];
    t_midi_beat   byte_results [$];
    int unsigned  mismatches = 0;
    int unsigned  pace = 0;
    logic         in_taken = 1'b0;

    t_parse_phase    phase;
    logic [6:0]      delta_groups [0:MAX_HELD-1];
    int unsigned     groups_held;
    logic [7:0]      run_status;
    int unsigned     data_left;
    int unsigned     meta_left;
    logic            meta_ends_track;
    longint unsigned out_count;

    function automatic void clear_parser();
        phase = AWAIT_DELTA;
        foreach (delta_groups[i]) delta_groups[i] = 7'd0;
        groups_held = 0;
        run_status = 8'h00;
        data_left = 0;
        meta_left = 0;
        meta_ends_track = 1'b0;
        out_count = 0;
    endfunction

    function automatic void emit(input logic [7:0] b, input logic [1:0] st);
        t_midi_beat r;
        if (byte_results.size() < RESULT_ROOM) begin
            if (st <= ST_END && out_count < COUNT_MAX) out_count++;
            r.out_byte = (st <= ST_END) ? b : 8'h00;
            r.status = st;
            r.run_last = 1'b0;
            r.bytes_written = out_count[15:0];
            byte_results.push_back(r);
        end
    endfunction

    function automatic void fail_track();
        byte_results.delete();
        emit(8'h00, ST_ERR);
        phase = TRACK_ERROR;
    endfunction

    function automatic void finish_meta();
        if (meta_ends_track) begin
            if (byte_results.size() > 0) byte_results[byte_results.size()-1].status = ST_END;
            phase = TRACK_DONE;
        end else begin
            phase = AWAIT_DELTA;
        end
    endfunction

    function automatic void transcode_byte(input logic [7:0] b, input logic start,
                                           input logic last);
        logic       idle_before;
        int         c;
        t_midi_beat r;
        byte_results.delete();
        if (start) clear_parser();
        idle_before = (phase == TRACK_DONE || phase == TRACK_ERROR);
        case (phase)
            AWAIT_DELTA: begin
                if ((b & BYTE_TOP) != 8'h00) begin
                    c = groups_held;
                    emit({c != 0, b[6:0]}, ST_BYTE);
                    while (c > 0) begin
                        c--;
                        emit({c != 0, delta_groups[c]}, ST_BYTE);
                    end
                    groups_held = 0;
                    phase = AWAIT_STATUS;
                end else if (groups_held >= MAX_HELD) begin
                    fail_track();
                end else begin
                    delta_groups[groups_held] = b[6:0];
                    groups_held++;
                end
            end
            AWAIT_STATUS: begin
                if (b == BYTE_META) begin
                    emit(b, ST_BYTE);
                    phase = META_TYPE;
                end else if ((b & BYTE_TOP) == 8'h00 || b[7:4] == NIB_SYS) begin
                    fail_track();
                end else begin
                    data_left = (b[7:4] == NIB_PROG || b[7:4] == NIB_PRESS) ? 1 : 2;
                    if (b != run_status) emit(b, ST_BYTE);
                    run_status = b;
                    phase = CHAN_DATA;
                end
            end
            CHAN_DATA: begin
                emit(b, ST_BYTE);
                if (data_left > 0) data_left--;
                if (data_left == 0) phase = AWAIT_DELTA;
            end
            META_TYPE: begin
                emit(b, ST_BYTE);
                meta_ends_track = (b == META_EOT);
                phase = META_LEN;
            end
            META_LEN: begin
                emit(b, ST_BYTE);
                meta_left = b;
                if (meta_left == 0) finish_meta();
                else phase = META_DATA;
            end
            META_DATA: begin
                emit(b, ST_BYTE);
                if (meta_left > 0) meta_left--;
                if (meta_left == 0) finish_meta();
            end
            default: begin
            end
        endcase
        if (last && !idle_before && phase != TRACK_DONE && phase != TRACK_ERROR) begin
            if (phase == AWAIT_DELTA && groups_held == 0) begin
                emit(8'h00, ST_LEN);
                phase = TRACK_DONE;
            end else begin
                fail_track();
            end
        end
        foreach (byte_results[k]) begin
            if (k < 4) begin
                r = byte_results[k];
                r.run_last = (k == byte_results.size() - 1 || k == 3);
                midi_expected.push_back(r);
            end
        end
    endfunction

    function automatic void note_mismatch(input string why, input t_midi_beat want,
                                          input t_midi_beat got);
        mismatches++;
        if (mismatches <= 10) begin
            $write("mismatch (%s): expected byte %h status %0d last %0d count %0d, ",
                   why, want.out_byte, want.status, want.run_last, want.bytes_written);
            $display("got byte %h status %0d last %0d count %0d",
                     got.out_byte, got.status, got.run_last, got.bytes_written);
        end
    endfunction

    task automatic add_delta(input int unsigned groups);
        for (int g = 1; g < groups; g++) trk.push_back(8'($urandom_range(127)));
        trk.push_back(8'($urandom) | BYTE_TOP);
    endtask

    task automatic add_channel(input logic [7:0] chan);
        trk.push_back(chan);
        trk.push_back(8'($urandom));
        if (chan[7:4] != NIB_PROG && chan[7:4] != NIB_PRESS) trk.push_back(8'($urandom));
    endtask

    task automatic add_meta(input logic [7:0] kind, input int unsigned len);
        trk.push_back(BYTE_META);
        trk.push_back(kind);
        trk.push_back(8'(len));
        repeat (len) trk.push_back(8'($urandom));
    endtask

    task automatic send_track(input int unsigned pace_sel, input bit with_last,
                              input bit noisy);
        t_track_beat tb_beat;
        foreach (trk[i]) begin
            tb_beat.in_byte = trk[i];
            tb_beat.track_start = (i == 0);
            tb_beat.track_last = noisy ? ($urandom_range(7) == 0)
                                       : (with_last && i == trk.size() - 1);
            tb_beat.pace = pace_sel;
            track_beats.push_back(tb_beat);
        end
        trk.delete();
    endtask

    task automatic random_track(input int unsigned pace_sel, inout int unsigned counted);
        int unsigned kind;
        int unsigned ending;
        logic [7:0]  chan;
        logic [7:0]  mtype;
        bit          with_last;
        chan = {4'($urandom_range(8, 14)), 4'($urandom)};
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(3, 10)) trk.push_back(8'($urandom));
            counted += trk.size();
            send_track(pace_sel, 1'b0, 1'b1);
        end else begin
            repeat ($urandom_range(1, 6)) begin
                kind = $urandom_range(19);
                if (kind == 19) begin
                    repeat (MAX_DELTA_BYTES) trk.push_back(8'($urandom_range(127)));
                end else begin
                    add_delta(($urandom_range(2) == 0) ? $urandom_range(1, 4) : 1);
                    if (kind < 12) begin
                        if ($urandom_range(1) == 0) begin
                            chan = {4'($urandom_range(8, 14)), 4'($urandom)};
                        end
                        add_channel(chan);
                    end else if (kind < 17) begin
                        mtype = 8'($urandom);
                        if (mtype == META_EOT) mtype = 8'h01;
                        add_meta(mtype, $urandom_range(0, 4));
                    end else begin
                        trk.push_back(8'($urandom));
                    end
                end
            end
            ending = $urandom_range(9);
            with_last = 1'b1;
            if (ending < 6) begin
                add_delta($urandom_range(1, 2));
                add_meta(META_EOT, (ending == 0) ? $urandom_range(1, 3) : 0);
                with_last = ($urandom_range(3) != 0);
            end else if (ending == 8) begin
                add_delta(1);
                if ($urandom_range(1) == 0) trk.push_back(chan);
            end else if (ending == 9) begin
                with_last = 1'b0;
            end
            counted += trk.size();
            if (ending < 6 && $urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 3)) trk.push_back(8'($urandom));
            end
            send_track(pace_sel, with_last, 1'b0);
        end
    endtask

    always @(negedge i_clk) begin
        t_track_beat nxt;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (track_beats.size() != 0
                && $urandom_range(99) >= sender_idle_pct[track_beats[0].pace]) begin
                nxt = track_beats.pop_front();
                in_ch.in_byte <= nxt.in_byte;
                in_ch.track_start <= nxt.track_start;
                in_ch.track_last <= nxt.track_last;
                in_ch.valid <= 1'b1;
                pace <= nxt.pace;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready <= i_rst_n && ($urandom_range(99) >= receiver_idle_pct[pace]);
    end

    always @(posedge i_clk) begin
        t_midi_beat got;
        t_midi_beat want;
        in_taken <= in_ch.valid && in_ch.ready;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                transcode_byte(in_ch.in_byte, in_ch.track_start, in_ch.track_last);
            end
            if (out_ch.valid && out_ch.ready) begin
                got.out_byte = out_ch.out_byte;
                got.status = out_ch.status;
                got.run_last = out_ch.run_last;
                got.bytes_written = out_ch.bytes_written;
                if (midi_expected.size() == 0) begin
                    note_mismatch("no result expected", '0, got);
                end else begin
                    want = midi_expected.pop_front();
                    if (got.out_byte !== want.out_byte || got.status !== want.status
                        || got.run_last !== want.run_last
                        || got.bytes_written !== want.bytes_written) begin
                        note_mismatch("wrong field", want, got);
                    end
                end
            end
        end
    end

    initial begin
        int unsigned counted;
        in_ch.valid = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.track_start = 1'b0;
        in_ch.track_last = 1'b0;
        out_ch.ready = 1'b0;
        clear_parser();
        counted = 0;

        // Longest delta, running status, top-bit data bytes, end-of-track meta.
        trk = '{8'h80, 8'h90, 8'h00, 8'h7F, 8'h7F, 8'h00, 8'h7F, 8'hFF,
                8'h90, 8'hFF, 8'hFF, 8'h80, BYTE_META, META_EOT, 8'h00};
        send_track(0, 1'b1, 1'b0);
        trk = '{8'h00, 8'h7F, 8'h00, 8'h00};
        send_track(0, 1'b0, 1'b0);
        trk = '{8'h80, 8'h12};
        send_track(0, 1'b0, 1'b0);
        trk = '{8'h80, 8'hF0};
        send_track(0, 1'b0, 1'b0);
        trk = '{8'h80, BYTE_META, 8'h01, 8'h00};
        send_track(0, 1'b1, 1'b0);
        trk = '{8'h12};
        send_track(0, 1'b1, 1'b0);

        while (counted < RANDOM_BEATS) random_track((counted * 3) / RANDOM_BEATS, counted);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (track_beats.size() != 0 || in_ch.valid) @(negedge i_clk);
        while (midi_expected.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        if (mismatches == 0 && midi_expected.size() == 0) begin
            $display("PASS hmi_to_midi_track_transcoder_core");
        end else begin
            $display("FAIL hmi_to_midi_track_transcoder_core");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("FAIL hmi_to_midi_track_transcoder_core");
        $finish;
    end

endmodule
